[src/lcdn_pkg.sv]
// Shared types, codes and the power-up sequence table for the character LCD nibble interface.
`timescale 1ns / 1ps

package lcdn_pkg;

	// Action codes carried on the input stream
	typedef enum logic [2:0] {
		ACT_INIT  = 3'd0,
		ACT_CLEAR = 3'd1,
		ACT_BEGIN = 3'd2,
		ACT_CHAR  = 3'd3,
		ACT_END   = 3'd4
	} action_t;

	// Which source feeds the output register
	typedef enum logic [1:0] {
		EMIT_INIT,
		EMIT_HI,
		EMIT_LO
	} emit_t;

	// One nibble transfer towards the display
	typedef struct packed {
		logic        rs;
		logic [3:0]  nibble;
		logic [15:0] wait_before;
		logic [12:0] wait_after;
	} xfer_t;

	// Controller to datapath
	typedef struct packed {
		logic  load;
		logic  emit_en;
		emit_t emit_sel;
		logic  last;
		logic  col_clr;
		logic  col_inc;
		logic  step_clr;
		logic  step_inc;
	} lcdn_cmd_t;

	// Datapath to controller
	typedef struct packed {
		action_t act;
		logic    ch_zero;
		logic    row_full;
		logic    init_last;
		logic    out_free;
	} lcdn_status_t;

	localparam logic [7:0]  CMD_CLEAR     = 8'h01;
	localparam logic [7:0]  ADDR_ROW0     = 8'h80;
	localparam logic [7:0]  ADDR_ROW1     = 8'hC0;
	localparam logic [7:0]  CHAR_SPACE    = 8'h20;
	localparam logic [3:0]  INIT_LEN      = 4'd12;
	localparam logic [12:0] WAIT_HI_US    = 13'd100;
	localparam logic [12:0] WAIT_LO_US    = 13'd200;
	localparam logic [12:0] WAIT_CLEAR_US = 13'd2200;

	// Power-up sequence: three wake nibbles, the switch to four bits, then
	// function set, display on, entry mode and clear, high nibble first.
	function automatic xfer_t init_xfer(input logic [3:0] step);
		xfer_t x;
		x.rs          = 1'b0;
		x.wait_before = 16'd0;
		unique case (step)
			4'd0: begin
				x.nibble = 4'h3; x.wait_before = 16'd50000; x.wait_after = 13'd5100;
			end
			4'd1: begin x.nibble = 4'h3; x.wait_after = 13'd300; end
			4'd2: begin x.nibble = 4'h3; x.wait_after = WAIT_HI_US; end
			4'd3: begin x.nibble = 4'h2; x.wait_after = WAIT_HI_US; end
			4'd4: begin x.nibble = 4'h2; x.wait_after = WAIT_HI_US; end
			4'd5: begin x.nibble = 4'h8; x.wait_after = WAIT_LO_US; end
			4'd6: begin x.nibble = 4'h0; x.wait_after = WAIT_HI_US; end
			4'd7: begin x.nibble = 4'hC; x.wait_after = WAIT_LO_US; end
			4'd8: begin x.nibble = 4'h0; x.wait_after = WAIT_HI_US; end
			4'd9: begin x.nibble = 4'h6; x.wait_after = WAIT_LO_US; end
			4'd10: begin x.nibble = 4'h0; x.wait_after = WAIT_HI_US; end
			4'd11: begin x.nibble = 4'h1; x.wait_after = WAIT_CLEAR_US; end
			default: begin x.nibble = 4'h0; x.wait_after = 13'd0; end
		endcase
		return x;
	endfunction

endpackage

[src/lcdn_ctrl.sv]
// Sequencing state machine of the character LCD nibble interface.
`timescale 1ns / 1ps

module lcdn_ctrl
	import lcdn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  lcdn_status_t status,
	output lcdn_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_INIT,
		S_HI,
		S_LO
	} state_t;

	state_t state_q, state_d;
	logic   pad_q, pad_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.emit_sel = EMIT_HI;
		state_d = state_q;
		pad_d   = pad_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (status.act)
						ACT_INIT: begin
							cmd.load     = 1'b1;
							cmd.step_clr = 1'b1;
							state_d      = S_INIT;
						end
						ACT_CLEAR: begin
							cmd.load = 1'b1;
							pad_d    = 1'b0;
							state_d  = S_HI;
						end
						ACT_BEGIN: begin
							cmd.load    = 1'b1;
							cmd.col_clr = 1'b1;
							pad_d       = 1'b0;
							state_d     = S_HI;
						end
						ACT_CHAR, ACT_END: begin
							// Full row: the item is dropped without any transfer
							if (!status.row_full) begin
								cmd.load    = 1'b1;
								cmd.col_inc = 1'b1;
								pad_d       = (status.act == ACT_END) || status.ch_zero;
								state_d     = S_HI;
							end
						end
						default: ;
					endcase
				end
			end
			S_INIT: begin
				if (status.out_free) begin
					cmd.emit_en  = 1'b1;
					cmd.emit_sel = EMIT_INIT;
					cmd.step_inc = 1'b1;
					cmd.last     = status.init_last;
					if (status.init_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_HI: begin
				if (status.out_free) begin
					cmd.emit_en  = 1'b1;
					cmd.emit_sel = EMIT_HI;
					state_d      = S_LO;
				end
			end
			S_LO: begin
				if (status.out_free) begin
					cmd.emit_en  = 1'b1;
					cmd.emit_sel = EMIT_LO;
					// While padding, another space follows until the row is full
					if (pad_q && !status.row_full) begin
						cmd.col_inc = 1'b1;
						state_d     = S_HI;
					end else begin
						cmd.last = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			pad_q   <= pad_d;
		end
	end

endmodule

[src/lcdn_dp.sv]
// Datapath of the character LCD nibble interface: byte latch, counters and output register.
`timescale 1ns / 1ps

module lcdn_dp
	import lcdn_pkg::*;
#(
	parameter int LINE_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [2:0]   in_action,
	input  logic         in_row,
	input  logic [7:0]   in_char,
	input  lcdn_cmd_t    cmd,
	output lcdn_status_t status,
	output logic         out_valid,
	input  logic         out_ready,
	output xfer_t        out_xfer,
	output logic         out_last
);

	localparam int CW = $clog2(LINE_WIDTH + 1);
	localparam logic [CW-1:0] COL_FULL = CW'(LINE_WIDTH);

	logic [CW-1:0] col_q;
	logic [3:0]    step_q;
	logic [7:0]    byte_q;
	logic          rs_q;
	logic          extra_q;
	logic          out_valid_q;
	xfer_t         xfer_q;
	logic          last_q;
	action_t       act;
	xfer_t         next_xfer;

	assign act = action_t'(in_action);

	assign status.act       = act;
	assign status.ch_zero   = (in_char == 8'h00);
	assign status.row_full  = (col_q >= COL_FULL);
	assign status.init_last = (step_q == INIT_LEN - 4'd1);
	assign status.out_free  = !out_valid_q || out_ready;

	always_comb begin
		next_xfer = init_xfer(step_q);
		unique case (cmd.emit_sel)
			EMIT_HI: begin
				next_xfer.rs          = rs_q;
				next_xfer.nibble      = byte_q[7:4];
				next_xfer.wait_before = 16'd0;
				next_xfer.wait_after  = WAIT_HI_US;
			end
			EMIT_LO: begin
				next_xfer.rs          = rs_q;
				next_xfer.nibble      = byte_q[3:0];
				next_xfer.wait_before = 16'd0;
				next_xfer.wait_after  = extra_q ? WAIT_CLEAR_US : WAIT_LO_US;
			end
			default: ;
		endcase
	end

	// Byte to send for the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			extra_q <= (act == ACT_CLEAR);
			priority if (act == ACT_CLEAR) begin
				byte_q <= CMD_CLEAR;
				rs_q   <= 1'b0;
			end else if (act == ACT_BEGIN) begin
				byte_q <= in_row ? ADDR_ROW1 : ADDR_ROW0;
				rs_q   <= 1'b0;
			end else if (act == ACT_CHAR && in_char != 8'h00) begin
				byte_q <= in_char;
				rs_q   <= 1'b1;
			end else begin
				byte_q <= CHAR_SPACE;
				rs_q   <= 1'b1;
			end
		end
		if (cmd.emit_en) begin
			xfer_q <= next_xfer;
			last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= COL_FULL;
			step_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.col_clr) begin
				col_q <= '0;
			end else if (cmd.col_inc) begin
				col_q <= col_q + CW'(1);
			end
			if (cmd.step_clr) begin
				step_q <= 4'd0;
			end else if (cmd.step_inc) begin
				step_q <= step_q + 4'd1;
			end
			if (cmd.emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_xfer  = xfer_q;
	assign out_last  = last_q;

endmodule

[src/char_lcd_nibble_interface.sv]
// Top level of the character LCD nibble interface: streaming ports, controller and datapath.
`timescale 1ns / 1ps

// The block turns display actions (init, clear, line begin, line character and
// line end) into timed nibble transfers for a character LCD on a 4-bit bus, each
// transfer carrying register select, the nibble and the waits before and after
// it; bytes go high nibble first and the final transfer of an action is marked
// with tlast. Actions are handled one at a time: once an input transfer is taken,
// the controller emits one nibble per cycle into the output register whenever
// that register is free, and any stall on the output side holds the sequence. A
// character or line end on a full row, or an unused action code, is absorbed
// without output. The output register lets the next input be taken while the
// last result still waits. Rows are LINE_WIDTH columns wide; the row counts as
// full after reset until a line begin opens it.

module char_lcd_nibble_interface
	import lcdn_pkg::*;
#(
	parameter int LINE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic [3:0]  s_tuser,   // [2:0] action, [3] row
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] nibble, [19:4] wait_before_us,
	                               // [32:20] wait_after_us, [39:33] zero
	output logic        m_tuser,   // register_select
	output logic        m_tlast    // last
);

	lcdn_cmd_t    cmd;
	lcdn_status_t status;
	xfer_t        xfer;

	lcdn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lcdn_dp #(
		.LINE_WIDTH(LINE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_action (s_tuser[2:0]),
		.in_row    (s_tuser[3]),
		.in_char   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_xfer  (xfer),
		.out_last  (m_tlast)
	);

	assign m_tdata = {7'd0, xfer.wait_after, xfer.wait_before, xfer.nibble};
	assign m_tuser = xfer.rs;

	// Only the first wake nibble of init carries a wait before it.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[19:4] != 16'd0) |-> !m_tuser && (m_tdata[3:0] == 4'h3))
		else $error("wait before on a transfer other than the first wake nibble");

	// Character data ends on a low nibble, which never has the clear delay.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tlast |-> (m_tdata[32:20] == WAIT_LO_US))
		else $error("data run ended on something other than a low nibble");

	// While the controller works through an action it takes no new input.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_en |-> !s_tready)
		else $error("input ready while a transfer is being emitted");

	// A transfer marked last closes the action, so input is open next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_en && cmd.last |=> s_tready)
		else $error("input not reopened after the final transfer");

endmodule

[test/lcd_nibble_checker.sv]
// Checker for the character LCD nibble interface: predicts every nibble transfer and compares.
`timescale 1ns / 1ps

module lcd_nibble_checker
	import lcdn_pkg::*;
#(
	parameter int LINE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [3:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);

	localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
	localparam logic [7:0] DISPLAY_ON    = 8'h0C;
	localparam logic [7:0] ENTRY_INC     = 8'h06;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nibble;
		logic [15:0] wait_before;
		logic [12:0] wait_after;
		logic        last;
	} lcd_xfer_t;

	lcd_xfer_t  expected_xfers[$];
	int         columns_used;
	int         mismatches;

	function automatic void push_xfer(input logic rs, input logic [3:0] nib,
			input logic [15:0] pre_us, input logic [12:0] post_us);
		lcd_xfer_t x;
		x.rs          = rs;
		x.nibble      = nib;
		x.wait_before = pre_us;
		x.wait_after  = post_us;
		x.last        = 1'b0;
		expected_xfers.push_back(x);
	endfunction

	// High nibble first; the low nibble carries the execution time of the byte.
	function automatic void push_byte(input logic [7:0] value, input logic rs,
			input logic [12:0] extra_after);
		push_xfer(rs, value[7:4], 16'd0, 13'd100);
		push_xfer(rs, value[3:0], 16'd0, 13'd200 + extra_after);
	endfunction

	function automatic void push_padding();
		while (columns_used < LINE_WIDTH) begin
			push_byte(CHAR_SPACE, 1'b1, 13'd0);
			columns_used = columns_used + 1;
		end
	endfunction

	function automatic void predict_action(input logic [2:0] act, input logic row,
			input logic [7:0] ch);
		int        first;
		lcd_xfer_t tail;
		first = expected_xfers.size();
		case (act)
			ACT_INIT: begin
				push_xfer(1'b0, 4'h3, 16'd50000, 13'd5100);
				push_xfer(1'b0, 4'h3, 16'd0, 13'd300);
				push_xfer(1'b0, 4'h3, 16'd0, 13'd100);
				push_xfer(1'b0, 4'h2, 16'd0, 13'd100);
				push_byte(FUNC_SET_4BIT, 1'b0, 13'd0);
				push_byte(DISPLAY_ON, 1'b0, 13'd0);
				push_byte(ENTRY_INC, 1'b0, 13'd0);
				push_byte(CMD_CLEAR, 1'b0, 13'd2000);
			end
			ACT_CLEAR: push_byte(CMD_CLEAR, 1'b0, 13'd2000);
			ACT_BEGIN: begin
				push_byte(row ? ADDR_ROW1 : ADDR_ROW0, 1'b0, 13'd0);
				columns_used = 0;
			end
			ACT_CHAR: begin
				if (ch == 8'h00) begin
					push_padding();
				end else if (columns_used < LINE_WIDTH) begin
					push_byte(ch, 1'b1, 13'd0);
					columns_used = columns_used + 1;
				end
			end
			ACT_END: push_padding();
			default: ;
		endcase
		if (expected_xfers.size() > first) begin
			tail      = expected_xfers.pop_back();
			tail.last = 1'b1;
			expected_xfers.push_back(tail);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcd_xfer_t exp_x;
		if (!arst_n) begin
			expected_xfers.delete();
			columns_used = LINE_WIDTH;
			mismatches   = 0;
			fail_count  <= 0;
			pending     <= 0;
		end else begin
			// The result leaving now belongs to an earlier action, so it is
			// checked before anything taken at this edge is predicted.
			if (m_tvalid && m_tready) begin
				if (expected_xfers.size() == 0) begin
					$error("unexpected transfer: nibble %0h rs %0b", m_tdata[3:0], m_tuser);
					mismatches++;
				end else begin
					exp_x = expected_xfers.pop_front();
					if (m_tuser !== exp_x.rs) begin
						$error("register_select: expected %0d, got %0d", exp_x.rs, m_tuser);
						mismatches++;
					end
					if (m_tdata[3:0] !== exp_x.nibble) begin
						$error("nibble: expected %0d, got %0d", exp_x.nibble, m_tdata[3:0]);
						mismatches++;
					end
					if (m_tdata[19:4] !== exp_x.wait_before) begin
						$error("wait_before_us: expected %0d, got %0d",
							exp_x.wait_before, m_tdata[19:4]);
						mismatches++;
					end
					if (m_tdata[32:20] !== exp_x.wait_after) begin
						$error("wait_after_us: expected %0d, got %0d",
							exp_x.wait_after, m_tdata[32:20]);
						mismatches++;
					end
					if (m_tlast !== exp_x.last) begin
						$error("last: expected %0d, got %0d", exp_x.last, m_tlast);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_action(s_tuser[2:0], s_tuser[3], s_tdata);
			fail_count <= mismatches;
			pending    <= expected_xfers.size();
		end
	end

endmodule

[test/char_lcd_nibble_interface_test.sv]
// Top of the testbench: clock, reset, action stimulus, output back-pressure and the verdict.
`timescale 1ns / 1ps

module char_lcd_nibble_interface_test;
	import lcdn_pkg::*;

	// Action codes that the block must absorb without any output.
	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

	localparam int ITEM_TARGET = 330;
	localparam int MAX_IDLE    = 8;
	// Worst case is roughly 330 actions of 32 transfers, each held up by a full
	// receiver stall; the limit leaves a wide margin over that.
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	int   items_sent;
	// When set, neither side inserts idle cycles, giving back-to-back stretches.
	logic no_idle;

	char_lcd_nibble_interface i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	lcd_nibble_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Reset is applied once at the start and released on a clock edge.
	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Guard against a hang: any run that outlives the limit is a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: before each transfer it stalls for a random number of cycles.
	// tready is only lowered when a stall follows, so it is never lowered and
	// raised again within the same time step.
	initial begin
		int stall;
		m_tready <= 1'b0;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Offers one action and holds it until the transfer completes. tvalid is left
	// high afterwards, so a following action with no gap keeps it asserted.
	task automatic send_action(input logic [2:0] act, input logic row, input logic [7:0] ch);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= {row, act};
		do @(posedge clk); while (!s_tready);
		if (act <= ACT_END)
			items_sent++;
	endtask

	// Holds the sender back until every predicted transfer has been seen.
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// A well-formed row: the cursor address, some characters, and usually a
	// line end. A zero character now and then pads the row early instead.
	task automatic send_row();
		int n;
		logic [7:0] ch;
		send_action(ACT_BEGIN, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		n = $urandom_range(0, 20);
		repeat (n) begin
			ch = ($urandom_range(0, 11) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
			send_action(ACT_CHAR, 1'($urandom_range(0, 1)), ch);
		end
		if ($urandom_range(0, 3) != 0)
			send_action(ACT_END, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int pick;
		int seq;
		items_sent  = 0;
		no_idle     = 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= 8'h00;
		s_tuser    <= 4'h0;
		@(posedge arst_n);
		@(posedge clk);

		// Directed part. Straight after reset the row counts as full, so a
		// character or a line end must be swallowed without output.
		send_action(ACT_CHAR, 1'b0, 8'h41);
		send_action(ACT_END, 1'b1, 8'h00);
		send_action(ACT_UNUSED_LO, 1'b1, 8'hFF);
		send_action(ACT_UNUSED_LO + 3'd1, 1'b0, 8'h00);
		send_action(ACT_UNUSED_HI, 1'b1, 8'h80);
		send_action(ACT_INIT, 1'b1, 8'hFF);
		send_action(ACT_CLEAR, 1'b0, 8'h00);
		send_action(ACT_BEGIN, 1'b0, 8'h00);
		send_action(ACT_CHAR, 1'b1, 8'hFF);
		send_action(ACT_CHAR, 1'b0, 8'h01);
		// A zero character pads the rest of the row with spaces.
		send_action(ACT_CHAR, 1'b0, 8'h00);
		// The row is full now: another character and a line end do nothing.
		send_action(ACT_CHAR, 1'b1, 8'h55);
		send_action(ACT_END, 1'b0, 8'hAA);
		send_action(ACT_BEGIN, 1'b1, 8'hFF);
		send_action(ACT_CHAR, 1'b1, 8'hAA);
		send_action(ACT_CHAR, 1'b0, 8'h80);
		send_action(ACT_CHAR, 1'b1, 8'h7F);
		send_action(ACT_END, 1'b1, 8'h55);
		drain_outputs();

		// Random part, mostly whole rows with random content, with init, clear,
		// stray actions and unused codes mixed in as noise.
		seq = 0;
		while (items_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 5) == 0);
			pick = $urandom_range(0, 19);
			if (seq == 8 || pick == 19)
				drain_outputs();
			if (pick < 14) begin
				send_row();
			end else if (pick < 16) begin
				send_action(($urandom_range(0, 2) == 0) ? ACT_INIT : ACT_CLEAR,
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 2))
					0: send_action(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)),
						1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
					1: send_action(ACT_CHAR, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
					default: send_action(ACT_END, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
				endcase
			end
			seq++;
		end

		// Wait for every predicted transfer, then a little longer so that any
		// spurious extra transfer is still caught.
		s_tvalid <= 1'b0;
		no_idle   = 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
